[sv/lsp_pkg.sv]
// Shared types, constants and the half-degree sine table of the lidar scan point generator.
// Used by every module of the block; it depends on nothing else.

package lsp_pkg;

  // Fixed-point format of the sine table: unsigned Q1.F.
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W = TRIG_FRAC_BITS + 1;

  // Field widths.
  localparam int RANGE_W = 16;
  localparam int DEG_W = 8;
  localparam int POS_W = 17;
  localparam int CNT_W = 7;

  // Product widths of the shared multiplier.
  localparam int P1_W = RANGE_W + TRIG_W;
  localparam int PROD_W = P1_W + TRIG_W;

  // Sine table: sin(k/2 degrees) for k = 0..180.
  localparam int TAB_DEPTH = 181;
  localparam int TAB_IDX_W = 8;
  localparam int TRIG_ANG_W = 10;

  localparam logic [DEG_W-1:0] ANGLE_LIMIT = 8'd180;

  // Register map.
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_ANGLE_MAX = 2'd0;
  localparam logic [1:0] REG_VERT_MIN = 2'd1;
  localparam logic [1:0] REG_CALIB_PERIOD = 2'd2;

  localparam logic [DEG_W-1:0] ANGLE_MAX_RST = 8'd180;
  localparam logic [DEG_W-1:0] VERT_MIN_RST = 8'd20;
  localparam logic [CNT_W-1:0] CALIB_PERIOD_RST = 7'd100;

  // Q30 constants used while the table is built.
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic [TRIG_W-1:0] sine_tab_t [0:TAB_DEPTH-1];

  // Configuration registers as seen by the scan sequencer.
  typedef struct packed {
    logic [DEG_W-1:0] angle_max;
    logic [DEG_W-1:0] vert_min;
    logic [CNT_W-1:0] calib_period;
  } cfg_t;

  // Flags that one step of the scan produces.
  typedef struct packed {
    logic calib_next;
    logic scan_end;
  } step_info_t;

  // Truncating quotient by shift and subtract; only evaluated while the table is built.
  function automatic longint unsigned quot64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build the table by a Taylor series in Q30, evaluated at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint sum;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      x = quot64(64'(k) * PI_Q30 + 64'd180, 64'd360);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        div = 64'((2 * n) * (2 * n + 1));
        term = quot64((term * x2 + (64'd1 << 29)) >> 30, div);
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
        sum = longint'(ONE_Q30);
      end
      tab[k] = TRIG_W'((64'(sum) + (64'd1 << (29 - TRIG_FRAC_BITS)))
                       >> (30 - TRIG_FRAC_BITS));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Apply a sign to a magnitude and give the 17-bit two's complement field.
  function automatic logic [POS_W-1:0] apply_sign(logic [POS_W-1:0] mag, logic neg);
    return neg ? (~mag + POS_W'(1)) : mag;
  endfunction

  // Round a product of d, sine and cosine (2F fraction bits) half up.
  function automatic logic [POS_W-1:0] round_q2(logic [PROD_W-1:0] prod);
    logic [PROD_W:0] sum;
    sum = {1'b0, prod} + ((PROD_W + 1)'(1) << (2 * TRIG_FRAC_BITS - 1));
    return POS_W'(sum >> (2 * TRIG_FRAC_BITS));
  endfunction

  // Round a product of d and one sine (F fraction bits) half up.
  function automatic logic [POS_W-1:0] round_q1(logic [PROD_W-1:0] prod);
    logic [PROD_W:0] sum;
    sum = {1'b0, prod} + ((PROD_W + 1)'(1) << (TRIG_FRAC_BITS - 1));
    return POS_W'(sum >> TRIG_FRAC_BITS);
  endfunction

endpackage

[sv/lsp_trig.sv]
// Half-degree sine lookup with quadrant folding and a registered result.
// Depends on lsp_pkg for the sine table and widths.

module lsp_trig (
  input  logic                             clk,
  input  logic [lsp_pkg::TRIG_ANG_W-1:0]   angle,
  output logic [lsp_pkg::TRIG_W-1:0]       mag,
  output logic                             neg
);

  logic [lsp_pkg::TRIG_ANG_W-1:0] fold;
  logic                           fold_neg;

  // Fold the angle (half degrees, below 720) into the first quadrant.
  always_comb begin
    if (angle <= 10'd180) begin
      fold = angle;
      fold_neg = 1'b0;
    end else if (angle <= 10'd360) begin
      fold = 10'd360 - angle;
      fold_neg = 1'b0;
    end else if (angle <= 10'd540) begin
      fold = angle - 10'd360;
      fold_neg = 1'b1;
    end else begin
      fold = 10'd720 - angle;
      fold_neg = 1'b1;
    end
  end

  // Table read, registered.
  always_ff @(posedge clk) begin
    mag <= lsp_pkg::SINE_TAB[fold[lsp_pkg::TAB_IDX_W-1:0]];
    neg <= fold_neg;
  end

endmodule

[sv/lsp_mul.sv]
// Shared multiplier of the point datapath with a registered product.
// Depends on lsp_pkg for the operand and product widths.

module lsp_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lsp_pkg::P1_W-1:0]    a,
  input  logic [lsp_pkg::TRIG_W-1:0]  b,
  output logic [lsp_pkg::PROD_W-1:0]  prod
);

  // One product per cycle while en is high; the result holds while en is low.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= lsp_pkg::PROD_W'(a) * lsp_pkg::PROD_W'(b);
    end
  end

endmodule

[sv/lsp_scan.sv]
// Serpentine scan position and calibration counter.
// Depends on lsp_pkg for the configuration and step flag structs.

module lsp_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  lsp_pkg::cfg_t                 cfg,
  input  logic                          step,
  output logic [lsp_pkg::DEG_W-1:0]     vert_pos,
  output logic [lsp_pkg::DEG_W-1:0]     hori_pos,
  output lsp_pkg::step_info_t           info
);

  logic                         sweep_up;
  logic [lsp_pkg::CNT_W-1:0]    reading_count;
  logic [lsp_pkg::DEG_W-1:0]    vert_pos_next;
  logic [lsp_pkg::DEG_W-1:0]    hori_pos_next;
  logic                         sweep_up_next;
  logic [lsp_pkg::CNT_W-1:0]    reading_count_next;
  logic [lsp_pkg::DEG_W-1:0]    hi;
  logic [lsp_pkg::DEG_W-1:0]    lo;
  logic [lsp_pkg::CNT_W:0]      cnt_inc;
  logic                         scan_end;

  // Effective sweep limits.
  always_comb begin
    hi = (cfg.angle_max > lsp_pkg::ANGLE_LIMIT) ? lsp_pkg::ANGLE_LIMIT : cfg.angle_max;
    lo = (cfg.vert_min > hi) ? hi : cfg.vert_min;
  end

  // Next position along the scan.
  always_comb begin
    vert_pos_next = vert_pos;
    hori_pos_next = hori_pos;
    sweep_up_next = sweep_up;
    scan_end = 1'b0;
    if (!sweep_up) begin
      if (vert_pos > lo) begin
        vert_pos_next = vert_pos - 8'd1;
      end else begin
        hori_pos_next = hori_pos + 8'd1;
        vert_pos_next = lo;
        sweep_up_next = 1'b1;
      end
    end else begin
      if (vert_pos < hi) begin
        vert_pos_next = vert_pos + 8'd1;
      end else begin
        if (hori_pos >= hi) begin
          scan_end = 1'b1;
          hori_pos_next = '0;
        end else begin
          hori_pos_next = hori_pos + 8'd1;
        end
        vert_pos_next = hi;
        sweep_up_next = 1'b0;
      end
    end
  end

  // Calibration counter; a zero period behaves like a period of one.
  always_comb begin
    cnt_inc = {1'b0, reading_count} + (lsp_pkg::CNT_W + 1)'(1);
    if (scan_end || (cnt_inc >= {1'b0, cfg.calib_period})) begin
      reading_count_next = '0;
    end else begin
      reading_count_next = cnt_inc[lsp_pkg::CNT_W-1:0];
    end
    info.calib_next = (reading_count_next == '0);
    info.scan_end = scan_end;
  end

  // Position state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_pos <= lsp_pkg::ANGLE_LIMIT;
      hori_pos <= '0;
      sweep_up <= 1'b0;
      reading_count <= '0;
    end else if (step) begin
      vert_pos <= vert_pos_next;
      hori_pos <= hori_pos_next;
      sweep_up <= sweep_up_next;
      reading_count <= reading_count_next;
    end
  end

endmodule

[sv/lidar_scan_point_generator_top.sv]
// Top level of the lidar scan point generator: APB registers, sequencer and output stage.
// Depends on lsp_pkg, lsp_scan, lsp_trig and lsp_mul.
//
// Usage: each word on the input stream (s_*) is one range reading in centimetres. The block
// tags it with the current serpentine scan position, converts it to x, y and z using the
// half-degree sine table, and sends one word on the output stream (m_*). m_tlast marks the
// last point of a full scan, m_tuser says the next reading should be bias-corrected.
// A new reading is taken only once the sequencer has finished the last one: the shared
// multiplier forms d*sin(v), then x, y and z one after another, each after a registered
// table lookup. s_tready is high only while the sequencer waits for a reading.
// The output word sits in a register; the next reading is accepted while it waits, and a
// finished point waits in the last sequencer step until the receiver takes the earlier one.
// Reset (rst, synchronous) puts the registers at 180, 20 and 100, starts the scan at
// horizontal 0 and vertical 180 sweeping down, clears the counter and empties the output.
// The APB port writes registers at byte addresses 0, 4 and 8; pready is always high.
// Configuration should be written only while no reading is in flight; the block does not enforce it.

module lidar_scan_point_generator_top (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lsp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] range_reading
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z,
                                 // [66:51] range_echo, [74:67] vert_deg, [82:75] hori_deg,
                                 // [87:83] zero
  output logic        m_tuser,   // [0] calibrate_next
  output logic        m_tlast    // scan_end
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LK_SV,
    S_MUL_P,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_Z,
    S_RND_Y,
    S_DONE
  } state_t;

  state_t                           state;
  lsp_pkg::cfg_t                    cfg;
  lsp_pkg::step_info_t              step_info;
  lsp_pkg::step_info_t              item_info;
  logic [lsp_pkg::DEG_W-1:0]        vert_pos;
  logic [lsp_pkg::DEG_W-1:0]        hori_pos;
  logic [lsp_pkg::RANGE_W-1:0]      reading;
  logic [lsp_pkg::DEG_W-1:0]        vert_deg;
  logic [lsp_pkg::DEG_W-1:0]        hori_deg;
  logic [lsp_pkg::TRIG_ANG_W-1:0]   trig_angle;
  logic [lsp_pkg::TRIG_W-1:0]       trig_mag;
  logic                             trig_neg;
  logic                             mul_en;
  logic [lsp_pkg::P1_W-1:0]         mul_a;
  logic [lsp_pkg::PROD_W-1:0]       prod;
  logic [lsp_pkg::P1_W-1:0]         p1;
  logic                             neg_s;
  logic                             neg_x;
  logic                             neg_y;
  logic                             neg_z;
  logic [lsp_pkg::POS_W-1:0]        pos_x;
  logic [lsp_pkg::POS_W-1:0]        pos_y;
  logic [lsp_pkg::POS_W-1:0]        out_x;
  logic [lsp_pkg::POS_W-1:0]        out_y;
  logic [lsp_pkg::POS_W-1:0]        out_z;
  logic [lsp_pkg::RANGE_W-1:0]      out_echo;
  logic [lsp_pkg::DEG_W-1:0]        out_vert;
  logic [lsp_pkg::DEG_W-1:0]        out_hori;
  logic                             accept;
  logic                             out_free;
  logic                             cfg_wr;

  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      lsp_pkg::REG_ANGLE_MAX:    prdata = 32'(cfg.angle_max);
      lsp_pkg::REG_VERT_MIN:     prdata = 32'(cfg.vert_min);
      lsp_pkg::REG_CALIB_PERIOD: prdata = 32'(cfg.calib_period);
      default:                   prdata = '0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_max <= lsp_pkg::ANGLE_MAX_RST;
      cfg.vert_min <= lsp_pkg::VERT_MIN_RST;
      cfg.calib_period <= lsp_pkg::CALIB_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lsp_pkg::REG_ANGLE_MAX:    cfg.angle_max <= pwdata[lsp_pkg::DEG_W-1:0];
        lsp_pkg::REG_VERT_MIN:     cfg.vert_min <= pwdata[lsp_pkg::DEG_W-1:0];
        lsp_pkg::REG_CALIB_PERIOD: cfg.calib_period <= pwdata[lsp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  lsp_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (accept),
    .vert_pos (vert_pos),
    .hori_pos (hori_pos),
    .info     (step_info)
  );

  // Table angle for the lookup whose result the next step uses.
  always_comb begin
    unique case (state)
      S_LK_SV: trig_angle = lsp_pkg::TRIG_ANG_W'(vert_deg);
      S_MUL_P: trig_angle = {1'b0, hori_deg, 1'b0} + 10'd180;
      S_MUL_X: trig_angle = {1'b0, hori_deg, 1'b0};
      S_MUL_Y: trig_angle = lsp_pkg::TRIG_ANG_W'(vert_deg) + 10'd180;
      default: trig_angle = lsp_pkg::TRIG_ANG_W'(vert_deg);
    endcase
  end

  lsp_trig u_trig (
    .clk   (clk),
    .angle (trig_angle),
    .mag   (trig_mag),
    .neg   (trig_neg)
  );

  // Multiplier operand select: the range, or the range times sin(v).
  always_comb begin
    unique case (state)
      S_MUL_X: mul_a = prod[lsp_pkg::P1_W-1:0];
      S_MUL_Y: mul_a = p1;
      default: mul_a = lsp_pkg::P1_W'(reading);
    endcase
    mul_en = (state == S_MUL_P) || (state == S_MUL_X) ||
             (state == S_MUL_Y) || (state == S_MUL_Z);
  end

  lsp_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (trig_mag),
    .prod (prod)
  );

  // Sequencer, working registers and the output stage. The x and y products are rounded in
  // the step after the one that started them; z is rounded in S_DONE as the point is written out.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            reading <= s_tdata;
            vert_deg <= vert_pos;
            hori_deg <= hori_pos;
            item_info <= step_info;
            state <= S_LK_SV;
          end
        end
        S_LK_SV: begin
          state <= S_MUL_P;
        end
        S_MUL_P: begin
          neg_s <= trig_neg;
          state <= S_MUL_X;
        end
        S_MUL_X: begin
          p1 <= prod[lsp_pkg::P1_W-1:0];
          neg_x <= neg_s ^ trig_neg;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          pos_x <= lsp_pkg::apply_sign(lsp_pkg::round_q2(prod), neg_x);
          neg_y <= neg_s ^ trig_neg;
          state <= S_MUL_Z;
        end
        S_MUL_Z: begin
          pos_y <= lsp_pkg::apply_sign(lsp_pkg::round_q2(prod), neg_y);
          neg_z <= trig_neg;
          state <= S_RND_Y;
        end
        S_RND_Y: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_x <= pos_x;
            out_y <= pos_y;
            out_z <= lsp_pkg::apply_sign(lsp_pkg::round_q1(prod), neg_z);
            out_echo <= reading;
            out_vert <= vert_deg;
            out_hori <= hori_deg;
            m_tuser <= item_info.calib_next;
            m_tlast <= item_info.scan_end;
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, out_hori, out_vert, out_echo, out_z, out_y, out_x};

endmodule
